/* hdl/drc_pkg.sv */
// shared types and constants of the dirty rectangle coalescer
`default_nettype none
package drc_pkg;
    localparam int MAX_BOXES  = 256;
    localparam int IDX_BITS   = 8;
    localparam int CNT_BITS   = 9;
    localparam int COORD_BITS = 11;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int DIM_BITS   = 12;

    typedef struct packed {
        logic [COORD_BITS-1:0] l;
        logic [COORD_BITS-1:0] t;
        logic [COORD_BITS-1:0] r;
        logic [COORD_BITS-1:0] b;
    } t_box;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_FLIP = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_MERGED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_REJECTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_FLIPPED  = 3'd4,
        ST_READ_OK  = 3'd5,
        ST_BAD_IDX  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_AREA, S_SCAN, S_EA, S_UA, S_APPEND, S_FRD, S_FLD, S_RDOUT, S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [IDX_BITS-1:0] idx;
        t_box                box;
    } t_res;
endpackage
`default_nettype wire

/* hdl/dirty_rectangle_coalescer.sv */
// top level of the dirty rectangle coalescer: sequencer, tables and stream ports
// usage:
//   requests enter on the s_axis group; tuser carries the op (add, flip, read),
//   tdata carries the rectangle edges and the read index. one result per
//   request leaves on the m_axis group, tuser carries the status. op 3 is
//   dropped without a result.
//   screen width and height are written through the cfg port (index 0, 1)
//   while the block is idle.
// sequencing:
//   an add passes S_AREA, then S_SCAN, S_EA and S_UA for each merged entry
//   examined until one merges; an add that appends or finds the merged list
//   full scans every merged entry and then passes S_APPEND; a rejected add or
//   a full frame list goes straight to S_DONE. a flip re-places each frame
//   entry the same way; a read passes S_RDOUT for an index below the merged
//   count. one shared area multiplier and one read port per table set this order.
//   the block takes one request at a time; s_axis_tready is high only when the
//   sequencer is idle. a finished result sits in a holding state until the
//   output register is free, so a stalled receiver holds the block.
// reset:
//   synchronous active-low reset empties both lists and sets 640 x 480.
//   table contents are not cleared; entries are read only below the counts.
`default_nettype none
module dirty_rectangle_coalescer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [11:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // rect_left, rect_top, rect_right, rect_bottom, read_index
    input  wire  [71:0] s_axis_tdata,
    // op
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // entry_index, out_left, out_top, out_right, out_bottom, current_count, pad
    output logic [63:0] m_axis_tdata,
    // status
    output logic [2:0]  m_axis_tuser
);
    localparam int CB = drc_pkg::COORD_BITS;
    localparam int IB = drc_pkg::IDX_BITS;
    localparam int NB = drc_pkg::CNT_BITS;
    localparam int AB = drc_pkg::AREA_BITS;
    localparam int DB = drc_pkg::DIM_BITS;

    // config registers
    logic [DB-1:0] r_width, r_height;
    logic [CB-1:0] w_wm1, w_hm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DB'(640);
            r_height <= DB'(480);
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_width  <= i_cfg_data;
            else                     r_height <= i_cfg_data;
        end
    end

    // largest legal coordinate: zero acts as one, above the limit saturates
    always_comb begin
        if (r_width == '0)                       w_wm1 = '0;
        else if (r_width > DB'(1 << CB))         w_wm1 = '1;
        else                                     w_wm1 = CB'(r_width - DB'(1));
        if (r_height == '0)                      w_hm1 = '0;
        else if (r_height > DB'(1 << CB))        w_hm1 = '1;
        else                                     w_hm1 = CB'(r_height - DB'(1));
    end

    // request fields
    drc_pkg::t_op       w_op;
    logic signed [15:0] w_l, w_t, w_r, w_b;
    logic [IB-1:0]      w_ridx;
    assign w_op   = drc_pkg::t_op'(s_axis_tuser);
    assign w_l    = s_axis_tdata[15:0];
    assign w_t    = s_axis_tdata[31:16];
    assign w_r    = s_axis_tdata[47:32];
    assign w_b    = s_axis_tdata[63:48];
    assign w_ridx = s_axis_tdata[71:64];

    // clamp to screen and check for inverted boxes
    logic signed [16:0] w_cl, w_ct, w_cr, w_cb;
    logic               w_reject;
    drc_pkg::t_box      w_clamped;
    always_comb begin
        w_cl = (w_l < 0) ? 17'sd0 : 17'(w_l);
        w_ct = (w_t < 0) ? 17'sd0 : 17'(w_t);
        w_cr = (17'(w_r) > $signed({6'd0, w_wm1})) ? $signed({6'd0, w_wm1}) : 17'(w_r);
        w_cb = (17'(w_b) > $signed({6'd0, w_hm1})) ? $signed({6'd0, w_hm1}) : 17'(w_b);
        w_reject    = (w_cl > w_cr) || (w_ct > w_cb);
        w_clamped.l = w_cl[CB-1:0];
        w_clamped.t = w_ct[CB-1:0];
        w_clamped.r = w_cr[CB-1:0];
        w_clamped.b = w_cb[CB-1:0];
    end

    // sequencer registers
    drc_pkg::t_state    r_state, n_state;
    logic [NB-1:0]      r_mcnt, n_mcnt, r_fcnt, n_fcnt;
    logic [NB-1:0]      r_idx, n_idx, r_fi, n_fi;
    logic               r_flip, n_flip;
    drc_pkg::t_box      r_nb, n_nb, r_u, n_u;
    logic signed [AB:0] r_an, n_an, r_ea, n_ea;
    drc_pkg::t_res      r_res, n_res;
    logic               r_ovalid, n_ovalid;
    drc_pkg::t_res      r_out, n_out;
    logic [NB-1:0]      r_ocnt, n_ocnt;

    // tables
    drc_pkg::t_box  r_mmem [drc_pkg::MAX_BOXES];
    drc_pkg::t_box  r_fmem [drc_pkg::MAX_BOXES];
    drc_pkg::t_box  r_mrd, r_frd;
    logic [IB-1:0]  w_maddr, w_mwaddr, w_faddr;
    logic           w_mwe, w_fwe;
    drc_pkg::t_box  w_mwdata;

    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mmem[w_mwaddr] <= w_mwdata;
        r_mrd <= r_mmem[w_maddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) r_fmem[r_fcnt[IB-1:0]] <= r_nb;
        r_frd <= r_fmem[w_faddr];
    end

    // shared area unit
    drc_pkg::t_box      w_abox;
    logic signed [AB:0] w_area;
    drc_area u_area (.i_box(w_abox), .o_area(w_area));

    always_comb begin
        unique case (r_state)
            drc_pkg::S_EA: w_abox = r_mrd;
            drc_pkg::S_UA: w_abox = r_u;
            default:       w_abox = r_nb;
        endcase
    end

    logic                 w_hit;
    logic signed [AB+1:0] w_sum;
    drc_pkg::t_box        w_ucl, w_nbcl;
    assign w_sum = (AB+2)'(r_ea) + (AB+2)'(r_an);
    assign w_hit = (AB+2)'(w_area) < w_sum;
    always_comb begin
        w_ucl    = r_u;
        w_ucl.b  = (r_u.b > w_hm1) ? w_hm1 : r_u.b;
        w_nbcl   = r_nb;
        w_nbcl.b = (r_nb.b > w_hm1) ? w_hm1 : r_nb.b;
    end

    assign s_axis_tready = (r_state == drc_pkg::S_IDLE);
    logic w_take, w_load;
    assign w_take = s_axis_tvalid && s_axis_tready;
    assign w_load = (r_state == drc_pkg::S_DONE) && (!r_ovalid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drc_pkg::S_IDLE: begin
                if (w_take) begin
                    unique case (w_op)
                        drc_pkg::OP_ADD: begin
                            if (w_reject || r_fcnt >= NB'(drc_pkg::MAX_BOXES))
                                n_state = drc_pkg::S_DONE;
                            else
                                n_state = drc_pkg::S_AREA;
                        end
                        drc_pkg::OP_FLIP: n_state = drc_pkg::S_FRD;
                        drc_pkg::OP_READ: begin
                            n_state = ({1'b0, w_ridx} < r_mcnt) ? drc_pkg::S_RDOUT
                                                                : drc_pkg::S_DONE;
                        end
                        default: n_state = drc_pkg::S_IDLE;
                    endcase
                end
            end
            drc_pkg::S_AREA: n_state = drc_pkg::S_SCAN;
            drc_pkg::S_SCAN: n_state = (r_idx >= r_mcnt) ? drc_pkg::S_APPEND : drc_pkg::S_EA;
            drc_pkg::S_EA:   n_state = drc_pkg::S_UA;
            drc_pkg::S_UA: begin
                if (!w_hit)     n_state = drc_pkg::S_SCAN;
                else if (r_flip) n_state = drc_pkg::S_FRD;
                else            n_state = drc_pkg::S_DONE;
            end
            drc_pkg::S_APPEND: n_state = r_flip ? drc_pkg::S_FRD : drc_pkg::S_DONE;
            drc_pkg::S_FRD:    n_state = (r_fi >= r_fcnt) ? drc_pkg::S_DONE : drc_pkg::S_FLD;
            drc_pkg::S_FLD:    n_state = drc_pkg::S_AREA;
            drc_pkg::S_RDOUT:  n_state = drc_pkg::S_DONE;
            drc_pkg::S_DONE:   n_state = w_load ? drc_pkg::S_IDLE : drc_pkg::S_DONE;
            default:           n_state = drc_pkg::S_IDLE;
        endcase
    end

    // datapath and table controls
    always_comb begin
        n_mcnt   = r_mcnt;
        n_fcnt   = r_fcnt;
        n_idx    = r_idx;
        n_fi     = r_fi;
        n_flip   = r_flip;
        n_nb     = r_nb;
        n_u      = r_u;
        n_an     = r_an;
        n_ea     = r_ea;
        n_res    = r_res;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_out    = r_out;
        n_ocnt   = r_ocnt;
        w_maddr  = r_idx[IB-1:0];
        w_mwaddr = r_idx[IB-1:0];
        w_mwe    = 1'b0;
        w_mwdata = w_ucl;
        w_faddr  = r_fi[IB-1:0];
        w_fwe    = 1'b0;
        unique case (r_state)
            drc_pkg::S_IDLE: begin
                w_maddr = w_ridx;
                if (w_take) begin
                    unique case (w_op)
                        drc_pkg::OP_ADD: begin
                            n_nb   = w_clamped;
                            n_flip = 1'b0;
                            n_res  = '{status: w_reject ? drc_pkg::ST_REJECTED
                                                        : drc_pkg::ST_FULL,
                                       idx: '0, box: '0};
                        end
                        drc_pkg::OP_FLIP: begin
                            n_mcnt = '0;
                            n_fi   = '0;
                            n_flip = 1'b1;
                        end
                        drc_pkg::OP_READ: begin
                            n_idx = {1'b0, w_ridx};
                            n_res = '{status: drc_pkg::ST_BAD_IDX, idx: w_ridx, box: '0};
                        end
                        default: n_flip = r_flip;
                    endcase
                end
            end
            drc_pkg::S_AREA: begin
                n_an  = w_area;
                n_idx = '0;
            end
            drc_pkg::S_EA: begin
                n_ea  = w_area;
                n_u.l = (r_mrd.l >= r_nb.l) ? r_nb.l : r_mrd.l;
                n_u.r = (r_mrd.r <= r_nb.r) ? r_nb.r : r_mrd.r;
                n_u.t = (r_mrd.t >= r_nb.t) ? r_nb.t : r_mrd.t;
                n_u.b = (r_mrd.b <= r_nb.b) ? r_nb.b : r_mrd.b;
            end
            drc_pkg::S_UA: begin
                if (w_hit) begin
                    w_mwe = 1'b1;
                    if (r_flip) begin
                        n_fi = r_fi + NB'(1);
                    end else begin
                        w_fwe  = 1'b1;
                        n_fcnt = r_fcnt + NB'(1);
                        n_res  = '{status: drc_pkg::ST_MERGED, idx: r_idx[IB-1:0],
                                   box: w_ucl};
                    end
                end else begin
                    n_idx = r_idx + NB'(1);
                end
            end
            drc_pkg::S_APPEND: begin
                w_mwaddr = r_mcnt[IB-1:0];
                w_mwdata = w_nbcl;
                if (r_flip) begin
                    // flip never overflows: frame count bounds merged count
                    w_mwe  = 1'b1;
                    n_mcnt = r_mcnt + NB'(1);
                    n_fi   = r_fi + NB'(1);
                end else if (r_mcnt >= NB'(drc_pkg::MAX_BOXES)) begin
                    n_res = '{status: drc_pkg::ST_FULL, idx: '0, box: '0};
                end else begin
                    w_mwe  = 1'b1;
                    n_mcnt = r_mcnt + NB'(1);
                    w_fwe  = 1'b1;
                    n_fcnt = r_fcnt + NB'(1);
                    n_res  = '{status: drc_pkg::ST_APPENDED, idx: r_mcnt[IB-1:0],
                               box: w_nbcl};
                end
            end
            drc_pkg::S_FRD: begin
                if (r_fi >= r_fcnt) begin
                    n_fcnt = '0;
                    n_res  = '{status: drc_pkg::ST_FLIPPED, idx: '0, box: '0};
                end
            end
            drc_pkg::S_FLD: n_nb = r_frd;
            drc_pkg::S_RDOUT: begin
                n_res = '{status: drc_pkg::ST_READ_OK, idx: r_idx[IB-1:0], box: r_mrd};
            end
            drc_pkg::S_DONE: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_ocnt   = r_mcnt;
                end
            end
            default: n_flip = r_flip;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= drc_pkg::S_IDLE;
            r_mcnt   <= '0;
            r_fcnt   <= '0;
            r_ovalid <= 1'b0;
            r_flip   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mcnt   <= n_mcnt;
            r_fcnt   <= n_fcnt;
            r_ovalid <= n_ovalid;
            r_flip   <= n_flip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_fi   <= n_fi;
        r_nb   <= n_nb;
        r_u    <= n_u;
        r_an   <= n_an;
        r_ea   <= n_ea;
        r_res  <= n_res;
        r_out  <= n_out;
        r_ocnt <= n_ocnt;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {3'd0, r_ocnt, r_out.box.b, r_out.box.r,
                            r_out.box.t, r_out.box.l, r_out.idx};

    // checks
    a_mcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= NB'(drc_pkg::MAX_BOXES))
        else $error("merged count above table size");
    a_fcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= NB'(drc_pkg::MAX_BOXES))
        else $error("frame count above table size");
    a_flip_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drc_pkg::S_DONE && r_res.status == drc_pkg::ST_FLIPPED)
            |-> r_fcnt == '0)
        else $error("frame list not empty after flip");
    a_flip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flip && r_state == drc_pkg::S_APPEND) |-> r_mcnt < r_fcnt)
        else $error("flip would overflow merged list");
endmodule
`default_nettype wire

/* hdl/drc_area.sv */
// area unit: (right - left) * (bottom - top) of one box
`default_nettype none
module drc_area (
    input  wire drc_pkg::t_box                  i_box,
    output logic signed [drc_pkg::AREA_BITS:0]  o_area
);
    // a merged entry can have its bottom above its top after the height shrinks,
    // so the height and the area are signed
    logic signed [drc_pkg::COORD_BITS:0] w_dx;
    logic signed [drc_pkg::COORD_BITS:0] w_dy;

    assign w_dx   = $signed({1'b0, i_box.r}) - $signed({1'b0, i_box.l});
    assign w_dy   = $signed({1'b0, i_box.b}) - $signed({1'b0, i_box.t});
    assign o_area = w_dx * w_dy;
endmodule
`default_nettype wire
